// ===== sv/int4_row_quantizer_assert.svh =====
// ----------------------------------------------------------------------------
// int4_row_quantizer assertion macros
// Concurrent assertion helpers clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef INT4_ROW_QUANTIZER_ASSERT_SVH
`define INT4_ROW_QUANTIZER_ASSERT_SVH

// Property that holds at every edge.
`define I4RQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define I4RQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/i4rq_pkg.sv =====
// ----------------------------------------------------------------------------
// i4rq_pkg
// Shared constants, types and divider request and response structs of the INT4 row quantizer.
// ----------------------------------------------------------------------------
package i4rq_pkg;

  localparam int unsigned MaxRow   = 64;
  localparam int unsigned AddrW    = $clog2(MaxRow);
  localparam int unsigned CntW     = AddrW + 1;

  localparam int unsigned DivNumW  = 76;
  localparam int unsigned DivQuotW = 29;
  localparam int unsigned DivDenW  = 24;
  localparam int unsigned DivHeadW = DivNumW - DivQuotW;
  localparam int unsigned DivCntW  = $clog2(DivQuotW);

  localparam logic [31:0]        ScaleOne        = 32'h3F80_0000;
  localparam int unsigned        ScalePreShift   = 6;
  localparam int unsigned        ScaleNumW       = 24 + ScalePreShift;
  localparam int unsigned        ScaleRecipW     = 31;
  localparam int unsigned        ScaleProdW      = ScaleNumW + ScaleRecipW;
  localparam int unsigned        ScaleRecipShift = 33;
  localparam logic [30:0]        ScaleRecip      = 31'h4924_924A;
  localparam logic [7:0]         ExpMax          = 8'hFF;
  localparam logic [3:0]         CodeMid         = 4'd8;
  localparam logic [3:0]         CodeMax         = 4'hF;
  localparam logic [3:0]         CodeMin         = 4'd1;
  localparam logic [2:0]         MagMax          = 3'd7;

  typedef enum logic [1:0] {
    KIND_SCALE = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SC,
    ST_SC_RND,
    ST_SC_OUT,
    ST_ERR_OUT,
    ST_RD,
    ST_EL,
    ST_EL_WAIT,
    ST_EL_RND,
    ST_BYTE_OUT
  } state_e;

  typedef struct packed {
    logic                start;
    logic [DivNumW-1:0]  numer;
    logic [DivDenW-1:0]  denom;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic                ovf;
    logic                rem_nz;
    logic [DivQuotW-1:0] quot;
  } div_rsp_t;

endpackage

// ===== sv/int4_row_quantizer.sv =====
// ----------------------------------------------------------------------------
// int4_row_quantizer
// Row-wise symmetric absmax INT4 quantizer for float32 weights.
// Requests on the input channel carry one weight; row_length_i, written with
// row_length_we_i while the block is idle, sets the row size (0 acts as 1,
// values above 64 as 64). Weights are taken one per cycle while a row loads;
// the last weight of a row starts the output phase and holds in_ready_o low.
// The output phase emits the row scale, then one byte per element pair with
// row_done_o on the last one, or a single error request for a bad scale.
// The scale is loaded into the output register from ST_SC_OUT after ST_SC
// and ST_SC_RND (ST_SC alone for an all-zero row), set by a reciprocal
// multiply by 1/7. Each element is then read from the row memory and, unless
// it is zero, NaN or far out of range, divided by the one-bit-per-cycle
// divider; each byte then goes out from ST_BYTE_OUT.
// A single output register parts the channels: a stalled receiver holds the
// sequencer at its next emit. Reset empties the row and sets the length to 64.
// ----------------------------------------------------------------------------
module int4_row_quantizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        row_length_we_i,
  input  logic [6:0]  row_length_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] weight_bits_i,
  input  logic        end_of_matrix_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] payload_o,
  output logic        row_done_o,
  output logic        matrix_done_o
);

  localparam int unsigned AW = i4rq_pkg::AddrW;
  localparam int unsigned CW = i4rq_pkg::CntW;
  localparam int unsigned QW = i4rq_pkg::DivQuotW;

  i4rq_pkg::state_e   state_q, state_d;
  logic [CW-1:0]      row_len_q;
  logic [CW-1:0]      fill_q, fill_d;
  logic [31:0]        absmax_q, absmax_d;
  logic [CW-1:0]      len_q, len_d;
  logic               eom_q, eom_d;
  logic [AW-1:0]      col_q, col_d;
  logic [31:0]        scale_q, scale_d;
  logic [7:0]         sexp_q, sexp_d;
  logic [3:0]         lo_q, lo_d;
  logic [3:0]         hi_q, hi_d;
  logic [QW-1:0]      sc_quot_q, sc_quot_d;
  logic               sc_rnz_q, sc_rnz_d;

  logic               out_valid_q;
  i4rq_pkg::kind_e    kind_q, out_kind;
  logic [31:0]        payload_q, out_payload;
  logic               rdone_q, out_rdone;
  logic               mdone_q, out_mdone;
  logic               out_load, out_free;

  logic [31:0]        row_mem [i4rq_pkg::MaxRow];
  logic [31:0]        rd_q;
  logic               mem_we, mem_re;

  i4rq_pkg::div_req_t div_req;
  i4rq_pkg::div_rsp_t div_rsp;

  logic               in_acc, row_end, w_nan, col_last;
  logic [CW-1:0]      len_eff, fill_inc;
  logic [31:0]        mag, absmax_upd;

  logic [23:0]        sc_ma;
  logic [i4rq_pkg::ScaleNumW-1:0]  sc_num;
  logic [i4rq_pkg::ScaleProdW-1:0] sc_prod;
  logic [QW-1:0]      sc_quot;
  logic               sc_rnz;
  logic [2:0]         sc_rp;
  logic [QW-1:0]      sc_keep, sc_gq;
  logic               sc_inc;
  logic [24:0]        sc_m;
  logic [7:0]         sc_ef;
  logic [31:0]        sc_bits;

  logic [7:0]         el_ew, el_es;
  logic [23:0]        el_mw;
  logic               el_nan, el_zero, el_big, el_small, el_neg;
  logic signed [9:0]  el_d;
  logic [9:0]         el_sh;
  logic [i4rq_pkg::DivNumW-1:0] el_numer;

  logic [QW-1:0]      rq;
  logic [2:0]         rk;
  logic               rtiny, rinc;
  logic [QW-1:0]      rkeep, rgq;
  logic [QW:0]        rval;
  logic [QW:0]        rsum;
  logic [3:0]         rt;
  logic [2:0]         rmag;
  logic [3:0]         el_code;

  logic               nib_we;
  logic [3:0]         nib;

  i4rq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o = (state_q == i4rq_pkg::ST_LOAD);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    priority if (row_len_q == '0) len_eff = CW'(1);
    else if (row_len_q > CW'(i4rq_pkg::MaxRow)) len_eff = CW'(i4rq_pkg::MaxRow);
    else len_eff = row_len_q;
    fill_inc   = fill_q + CW'(1);
    row_end    = fill_inc >= len_eff;
    mag        = {1'b0, weight_bits_i[30:0]};
    w_nan      = (weight_bits_i[30:23] == i4rq_pkg::ExpMax) && (weight_bits_i[22:0] != '0);
    absmax_upd = (!w_nan && (mag > absmax_q)) ? mag : absmax_q;
    col_last   = ({1'b0, col_q} + CW'(1)) >= len_q;
  end

  // Scale quotient: mantissa * 64 / 7 by reciprocal multiplication.
  always_comb begin
    sc_ma   = {absmax_q[30:23] != '0, absmax_q[22:0]};
    sc_num  = i4rq_pkg::ScaleNumW'(sc_ma) << i4rq_pkg::ScalePreShift;
    sc_prod = i4rq_pkg::ScaleProdW'(sc_num) * i4rq_pkg::ScaleProdW'(i4rq_pkg::ScaleRecip);
    sc_quot = QW'(sc_prod[i4rq_pkg::ScaleProdW-1:i4rq_pkg::ScaleRecipShift]);
    sc_rnz  = 32'(sc_num) != ({sc_quot, 3'b0} - {3'b0, sc_quot});
  end

  // Scale rounding: quotient of mantissa * 64 / 7, rounded to nearest even.
  always_comb begin
    sc_rp   = (sexp_q <= 8'd3) ? 3'(8'd7 - sexp_q) : (sc_quot_q[27] ? 3'd4 : 3'd3);
    sc_keep = sc_quot_q >> sc_rp;
    sc_gq   = sc_quot_q >> (sc_rp - 3'd1);
    sc_inc  = sc_gq[0] & (((sc_quot_q & ((QW'(1) << (sc_rp - 3'd1)) - QW'(1))) != '0)
              | sc_rnz_q | sc_keep[0]);
    sc_m    = sc_keep[24:0] + 25'(sc_inc);
    sc_ef   = sexp_q + 8'(sc_rp) - 8'd7;
    sc_bits = {1'b0, sc_ef, 23'b0} + {7'b0, sc_m};
  end

  // Element classification and divider operand.
  always_comb begin
    el_ew    = (rd_q[30:23] == '0) ? 8'd1 : rd_q[30:23];
    el_es    = (scale_q[30:23] == '0) ? 8'd1 : scale_q[30:23];
    el_mw    = {rd_q[30:23] != '0, rd_q[22:0]};
    el_neg   = rd_q[31];
    el_nan   = (rd_q[30:23] == i4rq_pkg::ExpMax) && (rd_q[22:0] != '0);
    el_zero  = el_mw == '0;
    el_d     = $signed({2'b0, el_ew}) - $signed({2'b0, el_es});
    el_big   = el_d >= 10'sd27;
    el_small = el_d <= -10'sd27;
    el_sh    = 10'(el_d + 10'sd26);
    el_numer = i4rq_pkg::DivNumW'(el_mw) << el_sh[5:0];
  end

  // Element rounding: float rounding of the quotient, then half away from zero.
  always_comb begin
    rq    = div_rsp.quot;
    rtiny = 1'b0;
    priority if (rq[28]) rk = 3'd5;
    else if (rq[27]) rk = 3'd4;
    else if (rq[26]) rk = 3'd3;
    else if (rq[25]) rk = 3'd2;
    else if (rq[24]) rk = 3'd1;
    else begin
      rk    = 3'd1;
      rtiny = 1'b1;
    end
    rkeep = rq >> rk;
    rgq   = rq >> (rk - 3'd1);
    rinc  = rgq[0] & (((rq & ((QW'(1) << (rk - 3'd1)) - QW'(1))) != '0)
            | div_rsp.rem_nz | rkeep[0]);
    rval  = ({1'b0, rkeep} + (QW+1)'(rinc)) << rk;
    rsum  = rval + ((QW+1)'(1) << 25);
    rt    = rsum[29:26];
    priority if (div_rsp.ovf) rmag = i4rq_pkg::MagMax;
    else if (rtiny) rmag = 3'd0;
    else if (rt > 4'(i4rq_pkg::MagMax)) rmag = i4rq_pkg::MagMax;
    else rmag = rt[2:0];
    el_code = el_neg ? (i4rq_pkg::CodeMid - 4'(rmag)) : (i4rq_pkg::CodeMid + 4'(rmag));
  end

  always_comb begin
    state_d       = state_q;
    fill_d        = fill_q;
    absmax_d      = absmax_q;
    len_d         = len_q;
    eom_d         = eom_q;
    col_d         = col_q;
    scale_d       = scale_q;
    sexp_d        = sexp_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    sc_quot_d     = sc_quot_q;
    sc_rnz_d      = sc_rnz_q;
    div_req       = '0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    out_load      = 1'b0;
    out_kind      = i4rq_pkg::KIND_SCALE;
    out_payload   = '0;
    out_rdone     = 1'b0;
    out_mdone     = 1'b0;
    nib_we        = 1'b0;
    nib           = i4rq_pkg::CodeMid;
    unique case (state_q)
      i4rq_pkg::ST_LOAD: begin
        if (in_acc) begin
          mem_we   = fill_q < CW'(i4rq_pkg::MaxRow);
          absmax_d = absmax_upd;
          fill_d   = fill_inc;
          if (row_end) begin
            fill_d  = '0;
            len_d   = len_eff;
            eom_d   = end_of_matrix_i;
            state_d = i4rq_pkg::ST_SC;
          end
        end
      end
      i4rq_pkg::ST_SC: begin
        absmax_d = '0;
        sexp_d   = (absmax_q[30:23] == '0) ? 8'd1 : absmax_q[30:23];
        priority if (absmax_q == '0) begin
          scale_d = i4rq_pkg::ScaleOne;
          state_d = i4rq_pkg::ST_SC_OUT;
        end else if (absmax_q[30:23] == i4rq_pkg::ExpMax) begin
          state_d = i4rq_pkg::ST_ERR_OUT;
        end else begin
          sc_quot_d = sc_quot;
          sc_rnz_d  = sc_rnz;
          state_d   = i4rq_pkg::ST_SC_RND;
        end
      end
      i4rq_pkg::ST_SC_RND: begin
        if (sc_bits == '0) begin
          state_d = i4rq_pkg::ST_ERR_OUT;
        end else begin
          scale_d = sc_bits;
          state_d = i4rq_pkg::ST_SC_OUT;
        end
      end
      i4rq_pkg::ST_SC_OUT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_kind    = i4rq_pkg::KIND_SCALE;
          out_payload = scale_q;
          col_d       = '0;
          state_d     = i4rq_pkg::ST_RD;
        end
      end
      i4rq_pkg::ST_ERR_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_kind  = i4rq_pkg::KIND_ERROR;
          out_rdone = 1'b1;
          out_mdone = eom_q;
          state_d   = i4rq_pkg::ST_LOAD;
        end
      end
      i4rq_pkg::ST_RD: begin
        mem_re  = 1'b1;
        state_d = i4rq_pkg::ST_EL;
      end
      i4rq_pkg::ST_EL: begin
        priority if (el_nan || el_zero || el_small) begin
          nib_we = 1'b1;
          nib    = i4rq_pkg::CodeMid;
        end else if (el_big) begin
          nib_we = 1'b1;
          nib    = el_neg ? i4rq_pkg::CodeMin : i4rq_pkg::CodeMax;
        end else begin
          div_req.start = 1'b1;
          div_req.numer = el_numer;
          div_req.denom = {scale_q[30:23] != '0, scale_q[22:0]};
          state_d       = i4rq_pkg::ST_EL_WAIT;
        end
      end
      i4rq_pkg::ST_EL_WAIT: begin
        if (div_rsp.done) state_d = i4rq_pkg::ST_EL_RND;
      end
      i4rq_pkg::ST_EL_RND: begin
        nib_we = 1'b1;
        nib    = el_code;
      end
      i4rq_pkg::ST_BYTE_OUT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_kind    = i4rq_pkg::KIND_BYTE;
          out_payload = {24'b0, hi_q, lo_q};
          if (col_last) begin
            out_rdone = 1'b1;
            out_mdone = eom_q;
            state_d   = i4rq_pkg::ST_LOAD;
          end else begin
            col_d   = col_q + AW'(1);
            state_d = i4rq_pkg::ST_RD;
          end
        end
      end
      default: state_d = i4rq_pkg::ST_LOAD;
    endcase
    // store nibble, then advance to the odd column or emit the byte
    if (nib_we) begin
      if (!col_q[0]) begin
        lo_d = nib;
        hi_d = i4rq_pkg::CodeMid;
      end else begin
        hi_d = nib;
      end
      if (!col_q[0] && !col_last) begin
        col_d   = col_q + AW'(1);
        state_d = i4rq_pkg::ST_RD;
      end else begin
        state_d = i4rq_pkg::ST_BYTE_OUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= i4rq_pkg::ST_LOAD;
      row_len_q   <= CW'(i4rq_pkg::MaxRow);
      fill_q      <= '0;
      absmax_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      absmax_q <= absmax_d;
      if (row_length_we_i) row_len_q <= row_length_i;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q     <= len_d;
    eom_q     <= eom_d;
    col_q     <= col_d;
    scale_q   <= scale_d;
    sexp_q    <= sexp_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    sc_quot_q <= sc_quot_d;
    sc_rnz_q  <= sc_rnz_d;
    if (out_load) begin
      kind_q    <= out_kind;
      payload_q <= out_payload;
      rdone_q   <= out_rdone;
      mdone_q   <= out_mdone;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) row_mem[fill_q[AW-1:0]] <= weight_bits_i;
    if (mem_re) rd_q <= row_mem[col_q];
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign payload_o     = payload_q;
  assign row_done_o    = rdone_q;
  assign matrix_done_o = mdone_q;

  `include "int4_row_quantizer_assert.svh"

  `I4RQ_ASSERT(a_load_div_idle, !in_ready_o || !div_rsp.busy, "divider busy while loading")
  `I4RQ_ASSERT(a_done_in_wait, !div_rsp.done || state_q == i4rq_pkg::ST_EL_WAIT, "stray done")
  `I4RQ_ASSERT_NEXT(a_row_end_scale, in_acc && row_end, state_q == i4rq_pkg::ST_SC, "row end did not start scale")
  `I4RQ_ASSERT(a_scale_not_last, !(out_valid_o && row_done_o) || kind_o != i4rq_pkg::KIND_SCALE, "scale marked as row end")

endmodule

// ===== sv/i4rq_div.sv =====
// ----------------------------------------------------------------------------
// i4rq_div
// Restoring divider, one quotient bit per cycle, low quotient bits with overflow.
// ----------------------------------------------------------------------------
module i4rq_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  i4rq_pkg::div_req_t req_i,
  output i4rq_pkg::div_rsp_t rsp_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [i4rq_pkg::DivCntW-1:0]       cnt_q, cnt_d;
  logic [i4rq_pkg::DivDenW-1:0]       rem_q, rem_d;
  logic [i4rq_pkg::DivDenW-1:0]       den_q, den_d;
  logic [i4rq_pkg::DivQuotW-1:0]      low_q, low_d;
  logic [i4rq_pkg::DivQuotW-1:0]      quot_q, quot_d;
  logic                               ovf_q, ovf_d;
  logic [i4rq_pkg::DivHeadW-1:0]      head;
  logic [i4rq_pkg::DivDenW:0]         trial;
  logic [i4rq_pkg::DivDenW:0]         diff;
  logic                               take;

  always_comb begin
    head   = req_i.numer[i4rq_pkg::DivNumW-1:i4rq_pkg::DivQuotW];
    trial  = {rem_q, low_q[i4rq_pkg::DivQuotW-1]};
    take   = trial >= {1'b0, den_q};
    diff   = trial - {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    low_d  = low_q;
    quot_d = quot_q;
    ovf_d  = ovf_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = i4rq_pkg::DivCntW'(i4rq_pkg::DivQuotW - 1);
      ovf_d  = head >= i4rq_pkg::DivHeadW'(req_i.denom);
      rem_d  = head[i4rq_pkg::DivDenW-1:0];
      low_d  = req_i.numer[i4rq_pkg::DivQuotW-1:0];
      quot_d = '0;
      den_d  = req_i.denom;
    end else if (busy_q) begin
      rem_d  = take ? diff[i4rq_pkg::DivDenW-1:0] : trial[i4rq_pkg::DivDenW-1:0];
      low_d  = {low_q[i4rq_pkg::DivQuotW-2:0], 1'b0};
      quot_d = {quot_q[i4rq_pkg::DivQuotW-2:0], take};
      cnt_d  = cnt_q - i4rq_pkg::DivCntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    low_q  <= low_d;
    quot_q <= quot_d;
    ovf_q  <= ovf_d;
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.ovf    = ovf_q;
  assign rsp_o.rem_nz = |rem_q;
  assign rsp_o.quot   = quot_q;

endmodule
